### rtl/core/gtpv2_ie_pattern_filter_assert.svh
// Assertion macros for the GTPv2 element pattern filter.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef GTPV2_IE_PATTERN_FILTER_ASSERT_SVH
`define GTPV2_IE_PATTERN_FILTER_ASSERT_SVH

// same-cycle implication
`define GTPIE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GTPIE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gtpie_pkg.sv
// Shared constants, codes and structs of the GTPv2 element pattern filter.
// No dependencies.
`timescale 1ns / 1ps

package gtpie_pkg;

    localparam int PATTERN_MAX  = 32;
    localparam int HEADER_BYTES = 12;

    // pattern byte address bits within one element type
    localparam int PAT_AW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int STORE_DEPTH = 256 << PAT_AW;
    localparam int CIDX_W      = 6;

    localparam logic [CIDX_W-1:0] CMP_DONE = 6'd63;
    localparam logic [CIDX_W-1:0] CIDX_MAX = CIDX_W'(PATTERN_MAX);

    localparam logic [1:0] FUNC_PAT_BYTE = 2'd0;
    localparam logic [1:0] FUNC_PAT_LEN  = 2'd1;
    localparam logic [1:0] FUNC_PKT      = 2'd2;

    localparam logic [1:0] VERDICT_FAIL = 2'd0;
    localparam logic [1:0] VERDICT_OFF  = 2'd1;
    localparam logic [1:0] VERDICT_PASS = 2'd2;

    typedef struct packed {
        logic              pat_we;
        logic              len_we;
        logic              valid_we;
        logic [7:0]        ie_type;
        logic [PAT_AW-1:0] pos;
        logic [7:0]        data;
        logic [5:0]        len;
        logic              enable;
    } t_pat_wr;

    typedef struct packed {
        logic [7:0]        kind;
        logic [CIDX_W-1:0] cidx;
    } t_rd_addr;

    typedef struct packed {
        logic       valid;
        logic [5:0] len;
        logic [7:0] pat_byte;
    } t_pat_rd;

    typedef struct packed {
        logic       vld;
        logic       last;
        logic [7:0] data;
    } t_pkt;

    typedef struct packed {
        logic       vld;
        logic [1:0] verdict;
    } t_res;

endpackage

### rtl/core/gtpie_pat_mem.sv
// Pattern byte store, pattern length table and per-type enable bits.
// Depends on gtpie_pkg. Reads are registered, same-cycle writes are forwarded.
`timescale 1ns / 1ps

module gtpie_pat_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gtpie_pkg::t_pat_wr  i_wr,
    input  gtpie_pkg::t_rd_addr i_rd_addr,
    output gtpie_pkg::t_pat_rd  o_rd
);

    logic [7:0]   r_store [gtpie_pkg::STORE_DEPTH];
    logic [5:0]   r_len_mem [256];
    logic [255:0] r_valid;
    logic [7:0]   r_rd_kind;
    logic [7:0]   r_byte_q;
    logic [5:0]   r_len_q;

    logic [gtpie_pkg::PAT_AW+7:0] w_wr_addr;
    logic [gtpie_pkg::PAT_AW+7:0] w_rd_addr;

    assign w_wr_addr = {i_wr.ie_type, i_wr.pos};
    assign w_rd_addr = {i_rd_addr.kind, i_rd_addr.cidx[gtpie_pkg::PAT_AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_wr.pat_we) begin
            r_store[w_wr_addr] <= i_wr.data;
        end
        if (i_wr.pat_we && (w_wr_addr == w_rd_addr)) begin
            r_byte_q <= i_wr.data;
        end else begin
            r_byte_q <= r_store[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.len_we) begin
            r_len_mem[i_wr.ie_type] <= i_wr.len;
        end
        if (i_wr.len_we && (i_wr.ie_type == i_rd_addr.kind)) begin
            r_len_q <= i_wr.len;
        end else begin
            r_len_q <= r_len_mem[i_rd_addr.kind];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_kind <= '0;
        end else begin
            r_rd_kind <= i_rd_addr.kind;
            if (i_wr.valid_we) begin
                r_valid[i_wr.ie_type] <= i_wr.enable;
            end
        end
    end

    // enable bits are flops: changes show up on the next cycle's compare
    assign o_rd.valid    = r_valid[r_rd_kind];
    assign o_rd.len      = r_len_q;
    assign o_rd.pat_byte = r_byte_q;

endmodule

### rtl/core/gtpie_parser.sv
// Message walker: header skip, element TLV walk, pattern compare and verdict.
// Depends on gtpie_pkg and gtpv2_ie_pattern_filter_assert.svh.
`timescale 1ns / 1ps
`include "gtpv2_ie_pattern_filter_assert.svh"

module gtpie_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  gtpie_pkg::t_pkt     i_pkt,
    input  gtpie_pkg::t_pat_rd  i_rd,
    output gtpie_pkg::t_rd_addr o_rd_addr,
    output gtpie_pkg::t_res     o_res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SPARE,
        PH_VALUE,
        PH_DONE
    } t_phase;

    t_phase r_phase, n_phase;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_msg_len, n_msg_len;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_kind, n_kind;
    logic [gtpie_pkg::CIDX_W-1:0] r_cidx, n_cidx;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_verdict, n_verdict;
    logic [7:0]  r_required;

    logic [16:0] w_limit;
    logic [7:0]  w_left_dec;
    logic [gtpie_pkg::CIDX_W-1:0] w_cidx_inc;
    logic [15:0] w_rem_dec;
    logic [1:0]  w_res_verdict;

    // element start must stay below message_length + 4 (body end in byte offsets)
    assign w_limit = (r_msg_len > 16'(gtpie_pkg::HEADER_BYTES - 4))
                   ? ({1'b0, r_msg_len} + 17'd4)
                   : 17'(gtpie_pkg::HEADER_BYTES);
    assign w_left_dec = r_left - 8'd1;
    assign w_cidx_inc = r_cidx + 6'd1;
    assign w_rem_dec  = r_rem - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_offset  = r_offset;
        n_msg_len = r_msg_len;
        n_rem     = r_rem;
        n_kind    = r_kind;
        n_cidx    = r_cidx;
        n_left    = r_left;
        n_verdict = r_verdict;
        w_res_verdict = gtpie_pkg::VERDICT_FAIL;

        if (i_pkt.vld) begin
            if (r_offset != 16'hFFFF) begin
                n_offset = r_offset + 16'd1;
            end
            case (r_phase)
                PH_HEADER: begin
                    if ((r_offset == 16'd0) && (r_required == 8'd0)) begin
                        n_phase   = PH_DONE;
                        n_verdict = gtpie_pkg::VERDICT_OFF;
                    end else begin
                        if (r_offset == 16'd0) begin
                            n_left = r_required;
                        end
                        if (r_offset == 16'd2) begin
                            n_msg_len = {i_pkt.data, 8'h00};
                        end
                        if (r_offset == 16'd3) begin
                            n_msg_len = r_msg_len | {8'h00, i_pkt.data};
                        end
                        if (r_offset >= 16'(gtpie_pkg::HEADER_BYTES - 1)) begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    if ({1'b0, r_offset} >= w_limit) begin
                        n_phase   = PH_DONE;
                        n_verdict = gtpie_pkg::VERDICT_FAIL;
                    end else begin
                        n_kind  = i_pkt.data;
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_rem   = {i_pkt.data, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_rem   = r_rem | {8'h00, i_pkt.data};
                    n_phase = PH_SPARE;
                end
                PH_SPARE: begin
                    n_cidx  = gtpie_pkg::CMP_DONE;
                    n_phase = (r_rem != 16'd0) ? PH_VALUE : PH_TYPE;
                    if (i_rd.valid) begin
                        if ({10'd0, i_rd.len} > r_rem) begin
                            n_phase   = PH_DONE;
                            n_verdict = gtpie_pkg::VERDICT_FAIL;
                        end else if (i_rd.len == 6'd0) begin
                            // empty pattern matches at once
                            n_left = w_left_dec;
                            if (w_left_dec == 8'd0) begin
                                n_phase   = PH_DONE;
                                n_verdict = gtpie_pkg::VERDICT_PASS;
                            end
                        end else begin
                            n_cidx = '0;
                        end
                    end
                end
                PH_VALUE: begin
                    n_rem   = w_rem_dec;
                    n_phase = (w_rem_dec == 16'd0) ? PH_TYPE : PH_VALUE;
                    if (i_rd.valid && (r_cidx < i_rd.len)) begin
                        if (i_pkt.data != i_rd.pat_byte) begin
                            n_rem     = r_rem;
                            n_phase   = PH_DONE;
                            n_verdict = gtpie_pkg::VERDICT_FAIL;
                        end else if (w_cidx_inc == i_rd.len) begin
                            n_cidx = gtpie_pkg::CMP_DONE;
                            n_left = w_left_dec;
                            if (w_left_dec == 8'd0) begin
                                n_rem     = r_rem;
                                n_phase   = PH_DONE;
                                n_verdict = gtpie_pkg::VERDICT_PASS;
                            end
                        end else begin
                            n_cidx = w_cidx_inc;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_pkt.last) begin
                w_res_verdict = (n_phase == PH_DONE) ? n_verdict : gtpie_pkg::VERDICT_FAIL;
                n_phase   = PH_HEADER;
                n_offset  = '0;
                n_msg_len = '0;
                n_rem     = '0;
                n_kind    = '0;
                n_cidx    = '0;
                n_left    = '0;
                n_verdict = gtpie_pkg::VERDICT_FAIL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_offset   <= '0;
            r_msg_len  <= '0;
            r_rem      <= '0;
            r_kind     <= '0;
            r_cidx     <= '0;
            r_left     <= '0;
            r_verdict  <= gtpie_pkg::VERDICT_FAIL;
            r_required <= '0;
        end else begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_msg_len <= n_msg_len;
            r_rem     <= n_rem;
            r_kind    <= n_kind;
            r_cidx    <= n_cidx;
            r_left    <= n_left;
            r_verdict <= n_verdict;
            if (i_cfg_we) begin
                r_required <= i_cfg_data;
            end
        end
    end

    // memory reads follow the next state so data is ready for the next word
    assign o_rd_addr.kind = n_kind;
    assign o_rd_addr.cidx = n_cidx;

    assign o_res.vld     = i_pkt.vld & i_pkt.last;
    assign o_res.verdict = w_res_verdict;

    `GTPIE_ASSERT_IMP(a_verdict_only_when_done, r_phase != PH_DONE,
        r_verdict == gtpie_pkg::VERDICT_FAIL, "verdict set without a decision")
    `GTPIE_ASSERT_IMP(a_cidx_in_range, r_cidx != gtpie_pkg::CMP_DONE,
        r_cidx <= gtpie_pkg::CIDX_MAX, "compare index past pattern end")
    `GTPIE_ASSERT_NXT(a_restart_after_last, i_pkt.vld && i_pkt.last,
        r_phase == PH_HEADER && r_offset == 16'd0, "parser did not restart after last word")

endmodule

### rtl/core/gtpie_out_buf.sv
// Output register with one skid entry for the verdict stream.
// Depends on gtpie_pkg.
`timescale 1ns / 1ps

module gtpie_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gtpie_pkg::t_res i_res,
    output logic            o_in_ready,
    output logic            o_valid,
    output logic [1:0]      o_verdict,
    input  logic            i_ready
);

    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_data, n_out_data;
    logic       r_skid_valid, n_skid_valid;
    logic [1:0] r_skid_data, n_skid_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_res.vld;
                n_out_data  = i_res.verdict;
            end
        end else if (i_res.vld) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_res.verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_in_ready = ~r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_verdict  = r_out_data;

endmodule

### rtl/core/gtpv2_ie_pattern_filter.sv
// GTPv2 information element pattern filter, top level.
// The verdict is registered in the output stage, or its skid entry while the output is held
// off, and shows on o_m_tvalid after the message's last word is taken. Throughput: one word
// per cycle, pattern loads and packet bytes alike, as the registered pattern store read is
// kept ahead of the walk; the input stalls only while a verdict waits in the skid entry.
// Reset (synchronous, active low) clears parser, output stage and pattern enables only.
`timescale 1ns / 1ps

module gtpv2_ie_pattern_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // data_byte[7:0], ie_type[15:8], pattern_pos[20:16],
                                    // pattern_enable[21], zero[23:22]
    input  logic [1:0]  i_s_tuser,  // func[1:0]
    input  logic        i_s_tlast,  // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // verdict[1:0], zero[7:2]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data  // required_matches
);

    logic                w_accept;
    logic [7:0]          w_data;
    logic [7:0]          w_type;
    logic [4:0]          w_pos;
    logic                w_enable;
    gtpie_pkg::t_pat_wr  w_wr;
    gtpie_pkg::t_pkt     w_pkt;
    gtpie_pkg::t_rd_addr w_rd_addr;
    gtpie_pkg::t_pat_rd  w_rd;
    gtpie_pkg::t_res     w_res;
    logic [1:0]          w_verdict;

    assign w_accept = i_s_tvalid & o_s_tready;
    assign w_data   = i_s_tdata[7:0];
    assign w_type   = i_s_tdata[15:8];
    assign w_pos    = i_s_tdata[20:16];
    assign w_enable = i_s_tdata[21];

    // pattern table writes
    assign w_wr.pat_we   = w_accept && (i_s_tuser == gtpie_pkg::FUNC_PAT_BYTE)
                        && ({1'b0, w_pos} < 6'(gtpie_pkg::PATTERN_MAX));
    assign w_wr.len_we   = w_accept && (i_s_tuser == gtpie_pkg::FUNC_PAT_LEN) && w_enable;
    assign w_wr.valid_we = w_accept && (i_s_tuser == gtpie_pkg::FUNC_PAT_LEN);
    assign w_wr.ie_type  = w_type;
    assign w_wr.pos      = gtpie_pkg::PAT_AW'(w_pos);
    assign w_wr.data     = w_data;
    assign w_wr.len      = (w_data > 8'(gtpie_pkg::PATTERN_MAX))
                         ? 6'(gtpie_pkg::PATTERN_MAX) : w_data[5:0];
    assign w_wr.enable   = w_enable;

    assign w_pkt.vld  = w_accept && (i_s_tuser == gtpie_pkg::FUNC_PKT);
    assign w_pkt.last = i_s_tlast;
    assign w_pkt.data = w_data;

    assign o_cfg_ready = 1'b1;

    gtpie_pat_mem u_pat_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_rd)
    );

    gtpie_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_pkt      (w_pkt),
        .i_rd       (w_rd),
        .o_rd_addr  (w_rd_addr),
        .o_res      (w_res)
    );

    gtpie_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_in_ready (o_s_tready),
        .o_valid    (o_m_tvalid),
        .o_verdict  (w_verdict),
        .i_ready    (i_m_tready)
    );

    assign o_m_tdata = {6'd0, w_verdict};

endmodule

### test/gtpv2_ie_verdict_checker.sv
// Verdict checker for the GTPv2 element pattern filter: predicts the verdict of each message
// from the words taken on the input and config channels and compares the output stream.
// Depends on gtpie_pkg.
`timescale 1ns / 1ps

module gtpv2_ie_verdict_checker
    import gtpie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,  // data_byte[7:0], ie_type[15:8], pattern_pos[20:16],
                                    // pattern_enable[21], zero[23:22]
    input  logic [1:0]  i_s_tuser,  // func[1:0]
    input  logic        i_s_tlast,  // last_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,  // verdict[1:0], zero[7:2]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_verdicts_due
);

    typedef enum logic [2:0] {
        WALK_HDR, WALK_TYPE, WALK_LEN_HI, WALK_LEN_LO, WALK_SPARE, WALK_VALUE, WALK_DONE
    } t_walk;

    logic [7:0]  pat_bytes [0:256*PATTERN_MAX-1];
    logic [5:0]  pat_len   [0:255];
    logic        pat_on    [0:255];
    logic [7:0]  need_count;

    t_walk       walk;
    logic [15:0] offs;
    logic [15:0] msg_len;
    logic [15:0] elem_left;
    logic [7:0]  elem_type;
    logic [5:0]  cmp_pos;
    logic [7:0]  left_to_match;
    logic [1:0]  verdict;
    logic        settled;

    logic [1:0]  expected_verdicts [$];
    logic [1:0]  want_verdict;

    initial begin
        o_fail_count   = 0;
        o_verdicts_due = 0;
        for (int i = 0; i < 256; i++) begin
            pat_len[i] = '0;
            pat_on[i]  = 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns verdict check: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic void conclude(input logic [1:0] v);
        verdict = v;
        settled = 1'b1;
        walk    = WALK_DONE;
    endfunction

    function automatic void restart_message();
        walk          = WALK_HDR;
        offs          = '0;
        msg_len       = '0;
        elem_left     = '0;
        elem_type     = '0;
        cmp_pos       = '0;
        left_to_match = '0;
        verdict       = VERDICT_FAIL;
        settled       = 1'b0;
    endfunction

    function automatic void note_match();
        cmp_pos       = CMP_DONE;
        left_to_match = left_to_match - 8'd1;
        if (left_to_match == 8'd0)
            conclude(VERDICT_PASS);
    endfunction

    function automatic void walk_packet_byte(input logic [7:0] b);
        int         body;
        int         rel;
        logic [5:0] plen;
        case (walk)
            WALK_HDR: begin
                if (offs == 16'd0 && need_count == 8'd0) begin
                    conclude(VERDICT_OFF);
                end else begin
                    if (offs == 16'd0)
                        left_to_match = need_count;
                    if (offs == 16'd2)
                        msg_len = {b, 8'h00};
                    if (offs == 16'd3)
                        msg_len[7:0] = b;
                    if (int'(offs) >= HEADER_BYTES - 1)
                        walk = WALK_TYPE;
                end
            end
            WALK_TYPE: begin
                // body counts from the first byte after the header
                body = (int'(msg_len) > HEADER_BYTES - 4) ? int'(msg_len) - (HEADER_BYTES - 4) : 0;
                rel  = int'(offs) - HEADER_BYTES;
                if (rel >= body) begin
                    conclude(VERDICT_FAIL);
                end else begin
                    elem_type = b;
                    walk      = WALK_LEN_HI;
                end
            end
            WALK_LEN_HI: begin
                elem_left = {b, 8'h00};
                walk      = WALK_LEN_LO;
            end
            WALK_LEN_LO: begin
                elem_left[7:0] = b;
                walk           = WALK_SPARE;
            end
            WALK_SPARE: begin
                cmp_pos = CMP_DONE;
                if (pat_on[elem_type]) begin
                    plen = pat_len[elem_type];
                    if (16'(plen) > elem_left)
                        conclude(VERDICT_FAIL);
                    else if (plen == 6'd0)
                        note_match();
                    else
                        cmp_pos = '0;
                end
                if (!settled)
                    walk = (elem_left != 16'd0) ? WALK_VALUE : WALK_TYPE;
            end
            WALK_VALUE: begin
                plen = pat_len[elem_type];
                if (pat_on[elem_type] && cmp_pos < plen) begin
                    if (b != pat_bytes[int'(elem_type) * PATTERN_MAX + int'(cmp_pos)]) begin
                        conclude(VERDICT_FAIL);
                    end else begin
                        cmp_pos = cmp_pos + 6'd1;
                        if (cmp_pos == plen)
                            note_match();
                    end
                end
                if (!settled) begin
                    elem_left = elem_left - 16'd1;
                    if (elem_left == 16'd0)
                        walk = WALK_TYPE;
                end
            end
            default: ;
        endcase
        if (offs != 16'hFFFF)
            offs = offs + 16'd1;
    endfunction

    function automatic void take_word(input logic [1:0] fn, input logic [7:0] dat,
                                      input logic [7:0] ty, input logic [4:0] pos,
                                      input logic en, input logic last);
        if (fn == FUNC_PAT_BYTE) begin
            if (int'(pos) < PATTERN_MAX)
                pat_bytes[int'(ty) * PATTERN_MAX + int'(pos)] = dat;
        end else if (fn == FUNC_PAT_LEN) begin
            if (en) begin
                pat_len[ty] = (int'(dat) > PATTERN_MAX) ? 6'(PATTERN_MAX) : dat[5:0];
                pat_on[ty]  = 1'b1;
            end else begin
                pat_on[ty] = 1'b0;
            end
        end else if (fn == FUNC_PKT) begin
            walk_packet_byte(dat);
            if (last) begin
                expected_verdicts.push_back(settled ? verdict : VERDICT_FAIL);
                restart_message();
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++)
                pat_on[i] = 1'b0;
            need_count = '0;
            restart_message();
            expected_verdicts.delete();
        end else begin
            // a result never stems from the word taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict word 0x%02h with none expected",
                                              i_m_tdata));
                end else begin
                    want_verdict = expected_verdicts.pop_front();
                    if (i_m_tdata[1:0] !== want_verdict || i_m_tdata[7:2] !== 6'd0)
                        report_mismatch($sformatf("verdict word 0x%02h, expected verdict %0d",
                                                  i_m_tdata, want_verdict));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                need_count = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                take_word(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[20:16],
                          i_s_tdata[21], i_s_tlast);
        end
        o_verdicts_due = expected_verdicts.size();
    end

endmodule

### test/gtpv2_ie_pattern_filter_tb.sv
// Testbench top for the GTPv2 element pattern filter: drives pattern loads, messages and
// required-match settings with random idling and back-pressure; verdicts are judged by
// gtpv2_ie_verdict_checker. Depends on gtpie_pkg and the filter RTL.
`timescale 1ns / 1ps

module gtpv2_ie_pattern_filter_tb;
    import gtpie_pkg::*;

    localparam logic [1:0] FUNC_IGNORED   = 2'd3;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         ITEMS_PER_PASS = 500;
    localparam int         MIN_MESSAGES   = 20;
    localparam int         CFG_EVERY      = 8;
    localparam int         POOL_SIZE      = 8;
    localparam logic [7:0] EMPTY_TYPE     = 8'h81;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;  // data_byte[7:0], ie_type[15:8], pattern_pos[20:16],
                             // pattern_enable[21], zero[23:22]
    logic [1:0]  i_s_tuser;  // func[1:0]
    logic        i_s_tlast;  // last_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;  // verdict[1:0], zero[7:2]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    int fail_count;
    int verdicts_due;

    int tx_idle_pct = 31;
    int rx_idle_pct = 61;
    bit hold_req;

    int items_sent;
    int messages_sent;

    // what the filter holds, kept so that messages can be built to match
    logic [7:0]  pat_img    [256][PATTERN_MAX];
    bit          pat_set    [256][PATTERN_MAX];
    int          pat_len_img[256];
    bit          pat_on_img [256];
    logic [7:0]  pool       [POOL_SIZE];
    logic [7:0]  msg_bytes  [$];

    always #2 i_clk = ~i_clk;

    gtpv2_ie_pattern_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    gtpv2_ie_verdict_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_s_tlast      (i_s_tlast),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_verdicts_due (verdicts_due)
    );

    task automatic push_word(input logic [1:0] fn, input logic [7:0] dat, input logic [7:0] ty,
                             input logic [4:0] pos, input logic en, input logic last);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, en, pos, ty, dat};
        i_s_tuser  <= fn;
        i_s_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            @(posedge i_clk);
        end while (!taken);
        if (fn != FUNC_IGNORED)
            items_sent++;
        if (fn == FUNC_PKT && last)
            messages_sent++;
    endtask

    task automatic push_packet_byte(input logic [7:0] dat, input logic last);
        push_word(FUNC_PKT, dat, 8'($urandom), 5'($urandom), 1'($urandom), last);
    endtask

    // sender pause: nothing offered until every verdict has come back
    task automatic drain_verdicts();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (verdicts_due != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_required(input logic [7:0] value);
        bit taken;
        drain_verdicts();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_required();
        case ($urandom_range(6))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'd1;
            4:       return 8'd2;
            5:       return 8'd3;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic int pick_pattern_len();
        case ($urandom_range(9))
            7:       return $urandom_range(7, PATTERN_MAX);
            8, 9:    return $urandom_range(PATTERN_MAX + 1, 255);  // saturates
            default: return $urandom_range(6);
        endcase
    endfunction

    task automatic write_pat_byte(input logic [7:0] ty, input logic [4:0] pos,
                                  input logic [7:0] value);
        push_word(FUNC_PAT_BYTE, value, ty, pos, 1'($urandom), 1'($urandom));
        pat_img[ty][pos] = value;
        pat_set[ty][pos] = 1'b1;
    endtask

    // every byte the new length covers gets written before the enable
    task automatic load_pattern(input logic [7:0] ty, input int raw_len);
        int eff;
        eff = (raw_len > PATTERN_MAX) ? PATTERN_MAX : raw_len;
        for (int p = 0; p < eff; p++)
            if (!pat_set[ty][p])
                write_pat_byte(ty, 5'(p), 8'($urandom));
        push_word(FUNC_PAT_LEN, 8'(raw_len), ty, 5'($urandom), 1'b1, 1'($urandom));
        pat_on_img[ty]  = 1'b1;
        pat_len_img[ty] = eff;
    endtask

    task automatic drop_pattern(input logic [7:0] ty);
        push_word(FUNC_PAT_LEN, 8'($urandom), ty, 5'($urandom), 1'b0, 1'($urandom));
        pat_on_img[ty] = 1'b0;
    endtask

    task automatic tweak_patterns();
        logic [7:0] ty;
        ty = pool[$urandom_range(POOL_SIZE - 1)];
        case ($urandom_range(9))
            6, 7:    load_pattern(ty, pick_pattern_len());
            8:       drop_pattern(ty);
            9:       write_pat_byte(8'($urandom), 5'($urandom), 8'($urandom));
            default: write_pat_byte(ty, 5'($urandom), 8'($urandom));
        endcase
    endtask

    task automatic send_msg_bytes(input bit mix_writes);
        for (int i = 0; i < msg_bytes.size(); i++) begin
            if (mix_writes && $urandom_range(99) < 3)
                tweak_patterns();
            push_packet_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
    endtask

    task automatic set_length(input logic [15:0] mlen);
        msg_bytes[2] = mlen[15:8];
        msg_bytes[3] = mlen[7:0];
    endtask

    // mostly well-formed: elements aimed at loaded patterns, with damage mixed in
    task automatic send_message();
        logic [7:0] ty;
        logic [7:0] b;
        int         n;
        int         vlen;
        int         plen;
        int         keep;
        msg_bytes.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            msg_bytes.push_back(8'($urandom));
        n = $urandom_range(4);
        for (int e = 0; e < n; e++) begin
            ty   = ($urandom_range(9) < 7) ? pool[$urandom_range(POOL_SIZE - 1)]
                                           : 8'($urandom);
            plen = pat_on_img[ty] ? pat_len_img[ty] : -1;
            if (plen < 0)
                vlen = $urandom_range(6);
            else if (plen > 0 && $urandom_range(9) == 0)
                vlen = $urandom_range(plen - 1);  // value shorter than the pattern
            else
                vlen = plen + $urandom_range(4);
            msg_bytes.push_back(ty);
            msg_bytes.push_back(8'(vlen >> 8));
            msg_bytes.push_back(8'(vlen));
            msg_bytes.push_back(8'($urandom));
            for (int i = 0; i < vlen; i++) begin
                b = (i < plen) ? pat_img[ty][i] : 8'($urandom);
                if (i < plen && $urandom_range(24) == 0)
                    b = b ^ 8'($urandom_range(1, 255));
                msg_bytes.push_back(b);
            end
        end
        case ($urandom_range(19))
            0, 1:    set_length(16'($urandom_range(HEADER_BYTES)));
            2:       set_length(16'($urandom));
            default: set_length(16'(msg_bytes.size() - 4));
        endcase
        case ($urandom_range(9))
            0:       repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
            1: begin
                keep = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > keep)
                    void'(msg_bytes.pop_back());
            end
            default: ;
        endcase
        send_msg_bytes(1'b1);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int  start_items;
        int  start_msgs;
        int  cfg_mark;
        int  r;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = FUNC_PAT_BYTE;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        items_sent    = 0;
        messages_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: filtering off, early end, field extremes, empty pattern
        write_required(8'd0);
        push_word(FUNC_IGNORED, 8'hFF, 8'hFF, 5'd31, 1'b1, 1'b1);
        push_word(FUNC_PKT, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1);
        write_required(8'd1);
        push_word(FUNC_PKT, 8'hFF, 8'hFF, 5'd31, 1'b1, 1'b1);
        write_pat_byte(8'hFF, 5'd31, 8'hFF);
        write_pat_byte(8'h00, 5'd0, 8'h00);
        load_pattern(EMPTY_TYPE, 0);
        msg_bytes.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            msg_bytes.push_back(8'h00);
        msg_bytes.push_back(EMPTY_TYPE);
        repeat (3) msg_bytes.push_back(8'h00);
        set_length(16'(msg_bytes.size() - 4));
        send_msg_bytes(1'b0);

        for (int k = 0; k < POOL_SIZE; k++) begin
            pool[k] = 8'($urandom);
            load_pattern(pool[k], pick_pattern_len());
        end

        for (int pass = 0; pass < 3; pass++) begin
            tx_idle_pct = (pass == 0) ? 31 : (pass == 1) ? 61 : 0;
            rx_idle_pct = (pass == 0) ? 61 : (pass == 1) ? 31 : 0;
            write_required((pass == 1) ? 8'd255 : pick_required());
            if (pass == 0) begin
                // back-pressure: single-byte messages against a stalled receiver
                hold_req = 1'b1;
                repeat (40) push_packet_byte(8'($urandom), 1'b1);
                drain_verdicts();
            end
            start_items = items_sent;
            start_msgs  = messages_sent;
            cfg_mark    = messages_sent;
            while (items_sent - start_items < ITEMS_PER_PASS ||
                   messages_sent - start_msgs < MIN_MESSAGES) begin
                if (messages_sent - cfg_mark >= CFG_EVERY) begin
                    write_required(pick_required());
                    cfg_mark = messages_sent;
                end
                r = $urandom_range(99);
                if (r < 80)
                    send_message();
                else if (r < 88)
                    repeat ($urandom_range(1, 6))
                        push_packet_byte(8'($urandom), $urandom_range(3) == 0);
                else if (r < 93)
                    tweak_patterns();
                else if (r < 97)
                    push_word(FUNC_IGNORED, 8'($urandom), 8'($urandom), 5'($urandom),
                              1'($urandom), 1'($urandom));
                else
                    write_pat_byte(8'($urandom), 5'($urandom), 8'($urandom));
            end
        end

        drain_verdicts();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
